// File: rtl/frvl_pkg.sv
// Package: types and constants for the fragment reassembly block with base-128 length.
package frvl_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int COUNT_BITS  = 32;
    localparam int SHIFT_BITS  = 6;

    localparam logic [7:0]            LEN_DATA_MASK = 8'h7F;
    localparam logic [SHIFT_BITS:0]   SHIFT_STEP    = 7'd7;
    localparam logic [SHIFT_BITS-1:0] SHIFT_MAX     = 6'd63;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEN  = 3'd1,
        PH_VER  = 3'd2,
        PH_DATA = 3'd3,
        PH_SKIP = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] pkt_byte;
        logic       packet_first;
        logic       packet_last;
    } in_t;

    typedef struct packed {
        logic [7:0]            payload_byte;
        logic                  payload_valid;
        logic                  message_done;
        logic [COUNT_BITS-1:0] collected_total;
    } out_t;

endpackage

// File: rtl/frvl_core.sv
// Reassembly state: packet phase, length decode, byte count and per-byte result.
module frvl_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_fire,
    input  frvl_pkg::in_t  in_item,
    output frvl_pkg::out_t result
);

    frvl_pkg::phase_t                     phase_reg, phase_next;
    logic                                 collecting_reg, collecting_next;
    logic [frvl_pkg::LENGTH_BITS-1:0]     exp_len_reg, exp_len_next;
    logic [frvl_pkg::SHIFT_BITS-1:0]      shift_reg, shift_next;
    logic [frvl_pkg::COUNT_BITS-1:0]      count_reg, count_next;

    logic                                 accepted;
    logic [frvl_pkg::LENGTH_BITS+6:0]     len_part;
    logic [frvl_pkg::SHIFT_BITS:0]        shift_sum;
    logic                                 done;

    // Next packet phase
    always_comb begin
        phase_next = phase_reg;
        if (in_item.packet_first) begin
            if (in_item.packet_last) begin
                phase_next = frvl_pkg::PH_IDLE;
            end else if (in_item.pkt_byte == 8'd0) begin
                phase_next = frvl_pkg::PH_LEN;
            end else if (collecting_reg) begin
                phase_next = frvl_pkg::PH_DATA;
            end else begin
                phase_next = frvl_pkg::PH_SKIP;
            end
        end else begin
            case (phase_reg)
                frvl_pkg::PH_LEN: begin
                    if (!in_item.pkt_byte[7]) begin
                        phase_next = frvl_pkg::PH_VER;
                    end
                end
                frvl_pkg::PH_VER: begin
                    phase_next = frvl_pkg::PH_DATA;
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
            if (in_item.packet_last) begin
                phase_next = frvl_pkg::PH_IDLE;
            end
        end
    end

    // Datapath and result
    always_comb begin
        collecting_next = collecting_reg;
        exp_len_next    = exp_len_reg;
        shift_next      = shift_reg;
        count_next      = count_reg;
        accepted        = 1'b0;
        done            = 1'b0;
        result          = '0;
        len_part        = {{(frvl_pkg::LENGTH_BITS){1'b0}},
                           in_item.pkt_byte[6:0] & frvl_pkg::LEN_DATA_MASK[6:0]} << shift_reg;
        shift_sum       = {1'b0, shift_reg} + frvl_pkg::SHIFT_STEP;

        if (in_item.packet_first) begin
            if (!in_item.packet_last && in_item.pkt_byte == 8'd0) begin
                collecting_next = 1'b1;
                count_next      = '0;
                exp_len_next    = '0;
                shift_next      = '0;
            end
        end else begin
            case (phase_reg)
                frvl_pkg::PH_LEN: begin
                    // drop length bits that land beyond the length register
                    if ({1'b0, shift_reg} < 7'(frvl_pkg::LENGTH_BITS)) begin
                        exp_len_next = exp_len_reg | len_part[frvl_pkg::LENGTH_BITS-1:0];
                    end
                    shift_next = shift_sum[frvl_pkg::SHIFT_BITS] ?
                                 frvl_pkg::SHIFT_MAX : shift_sum[frvl_pkg::SHIFT_BITS-1:0];
                    accepted = 1'b1;
                end
                frvl_pkg::PH_VER: begin
                    accepted = 1'b1;
                end
                frvl_pkg::PH_DATA: begin
                    result.payload_byte  = in_item.pkt_byte;
                    result.payload_valid = 1'b1;
                    if (count_reg != '1) begin
                        count_next = count_reg + 1'b1;
                    end
                    accepted = 1'b1;
                end
                default: begin
                    accepted = 1'b0;
                end
            endcase
            if (in_item.packet_last && accepted && exp_len_next != '0 &&
                count_next >= frvl_pkg::COUNT_BITS'(exp_len_next)) begin
                done            = 1'b1;
                collecting_next = 1'b0;
            end
        end

        result.message_done    = done;
        result.collected_total = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= frvl_pkg::PH_IDLE;
            collecting_reg <= 1'b0;
            exp_len_reg    <= '0;
            shift_reg      <= '0;
            count_reg      <= '0;
        end else if (in_fire) begin
            phase_reg      <= phase_next;
            collecting_reg <= collecting_next;
            exp_len_reg    <= exp_len_next;
            shift_reg      <= shift_next;
            count_reg      <= count_next;
        end
    end

endmodule

// File: rtl/fragment_reassembly_varint_length_top.sv
// Top level: byte-stream fragment reassembly with base-128 length prefix.
//
//   channel  dir  payload                       handshake
//   s_       in   in_t  (byte, first, last)     s_valid / s_ready
//   m_       out  out_t (byte, valid, done, cnt) m_valid / m_ready
//
// Each accepted byte updates the state in the same cycle and yields one result
// transaction in the output register on the next cycle: one byte per cycle.
// Throughput is set by the single output register; s_ready is high whenever
// it is empty or being drained. Reset (aresetn low, synchronous) clears the
// state and the output valid. A stall on m_ready holds the result and s_ready.
module fragment_reassembly_varint_length_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  frvl_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output frvl_pkg::out_t m_data
);

    logic           in_fire;
    frvl_pkg::out_t result;
    frvl_pkg::out_t out_reg;
    logic           out_valid_reg;

    assign s_ready = !out_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    frvl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_item (s_data),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result until the transaction completes
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: tb/tb.sv
// Testbench for the fragment reassembly block: scoreboard class, drivers, checks.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         ITEM_TARGET    = 1050;
    localparam int         QUIET_TAIL     = 100;
    localparam int         DRAIN_EVERY    = 300;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         MAX_REPORTS    = 10;
    localparam logic [7:0] START_MARK     = 8'h00;
    localparam logic [7:0] CONT_BIT       = 8'h80;

    class reassembly_scoreboard;
        bit               collecting;
        frvl_pkg::phase_t phase;
        logic [31:0]      length_goal;
        int unsigned      length_pos;
        logic [31:0]      payload_count;
        frvl_pkg::out_t   expected_q[$];
        int               errors;
        int               inputs;
        int               useful;
        int               results;
        int               messages;
        int               payloads;

        function new();
            collecting    = 1'b0;
            phase         = frvl_pkg::PH_IDLE;
            length_goal   = '0;
            length_pos    = 0;
            payload_count = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the reassembly state by one accepted transaction.
        function void note_input(frvl_pkg::in_t d);
            frvl_pkg::out_t r;
            bit             took;
            logic [63:0]    part;
            r    = '0;
            took = 1'b0;
            inputs++;
            if (d.packet_first) begin
                if (d.packet_last) begin
                    phase = frvl_pkg::PH_IDLE;
                end else if (d.pkt_byte == START_MARK) begin
                    collecting    = 1'b1;
                    payload_count = '0;
                    length_goal   = '0;
                    length_pos    = 0;
                    phase         = frvl_pkg::PH_LEN;
                    useful++;
                end else if (collecting) begin
                    phase = frvl_pkg::PH_DATA;
                    useful++;
                end else begin
                    phase = frvl_pkg::PH_SKIP;
                end
            end else begin
                case (phase)
                    frvl_pkg::PH_LEN: begin
                        if (length_pos < frvl_pkg::LENGTH_BITS) begin
                            part = 64'(d.pkt_byte & frvl_pkg::LEN_DATA_MASK) << length_pos;
                            length_goal = length_goal | part[31:0];
                        end
                        if (length_pos + frvl_pkg::SHIFT_STEP > frvl_pkg::SHIFT_MAX)
                            length_pos = frvl_pkg::SHIFT_MAX;
                        else
                            length_pos = length_pos + frvl_pkg::SHIFT_STEP;
                        if ((d.pkt_byte & CONT_BIT) == 8'h00)
                            phase = frvl_pkg::PH_VER;
                        took = 1'b1;
                    end
                    frvl_pkg::PH_VER: begin
                        phase = frvl_pkg::PH_DATA;
                        took  = 1'b1;
                    end
                    frvl_pkg::PH_DATA: begin
                        r.payload_byte  = d.pkt_byte;
                        r.payload_valid = 1'b1;
                        if (payload_count != '1)
                            payload_count++;
                        payloads++;
                        took = 1'b1;
                    end
                    default: ;
                endcase
                if (took)
                    useful++;
                if (d.packet_last) begin
                    if (took && length_goal != '0 && payload_count >= length_goal) begin
                        r.message_done = 1'b1;
                        collecting     = 1'b0;
                        messages++;
                    end
                    phase = frvl_pkg::PH_IDLE;
                end
            end
            r.collected_total = payload_count;
            expected_q = {expected_q, r};
        endfunction

        function void check_result(frvl_pkg::out_t got);
            frvl_pkg::out_t exp;
            results++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: result with nothing expected: %p", got);
                return;
            end
            exp = expected_q.pop_front();
            if (got.payload_byte !== exp.payload_byte
                    || got.payload_valid !== exp.payload_valid
                    || got.message_done !== exp.message_done
                    || got.collected_total !== exp.collected_total) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: result %0d mismatch: expected %p, got %p",
                             results, exp, got);
            end
        endfunction
    endclass

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    frvl_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    frvl_pkg::out_t m_data;

    reassembly_scoreboard sb;
    bit quiet       = 1'b0;
    int tx_rate     = 20;
    int rx_rate     = 20;
    int stall_left  = 0;
    int rx_age      = 0;
    int idle_cycles = 0;

    fragment_reassembly_varint_length_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Result side: stall in bursts, with the rate changing now and then.
    always @(posedge aclk) begin
        rx_age++;
        if (rx_age % 150 == 0)
            rx_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < rx_rate) begin
            m_ready    <= 1'b0;
            stall_left = $urandom_range(0, 16);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Observe both channels and run the watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            idle_cycles++;
            if (s_valid && s_ready) begin
                sb.note_input(s_data);
                idle_cycles = 0;
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
                idle_cycles = 0;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(logic [7:0] value, logic first, logic last);
        if (!quiet && $urandom_range(0, 99) < tx_rate) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid               <= 1'b1;
        s_data.pkt_byte       <= value;
        s_data.packet_first   <= first;
        s_data.packet_last    <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Send a packet; with open_end set the last mark is withheld.
    task automatic send_packet(logic [7:0] bytes[$], bit open_end);
        for (int i = 0; i < bytes.size(); i++)
            send_item(bytes[i], i == 0, (i == bytes.size() - 1) && !open_end);
    endtask

    // Drop valid, let the last transaction be noted, then wait for all results.
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Build a start packet: mark, base-128 length over groups, version, payload.
    task automatic build_header(int unsigned len_val, int extra, int head_payload,
                                ref logic [7:0] pkt[$]);
        int          groups;
        int unsigned rest;
        logic [7:0]  grp;
        groups = 1;
        rest   = len_val >> 7;
        while (rest != 0) begin
            groups++;
            rest = rest >> 7;
        end
        groups = groups + extra;
        pkt = {START_MARK};
        for (int g = 0; g < groups; g++) begin
            if (g * 7 >= 32)
                grp = 8'($urandom_range(0, 127));
            else
                grp = 8'((len_val >> (g * 7)) & 32'h7F);
            // fill bits that land above bit 31
            if (g == 4)
                grp = grp | (8'($urandom_range(0, 7)) << 4);
            if (g < groups - 1)
                grp = grp | CONT_BIT;
            pkt = {pkt, grp};
        end
        pkt = {pkt, 8'($urandom)};
        for (int i = 0; i < head_payload; i++)
            pkt = {pkt, 8'($urandom)};
    endtask

    task automatic send_message();
        logic [7:0]  pkt[$];
        int unsigned len_val;
        int          n_payload;
        int          head;
        int          chunk;
        int          extra;
        case ($urandom_range(0, 19))
            0:       len_val = 0;
            1:       len_val = $urandom_range(100, 300);
            default: len_val = $urandom_range(1, 30);
        endcase
        extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0;
        n_payload = int'(len_val);
        if ($urandom_range(0, 4) == 0)
            n_payload = n_payload + $urandom_range(0, 6) - 3;
        if (n_payload < 0)
            n_payload = 0;
        head = $urandom_range(0, (n_payload < 8) ? n_payload : 8);
        build_header(len_val, extra, head, pkt);
        send_packet(pkt, 1'b0);
        n_payload = n_payload - head;
        while (n_payload > 0) begin
            chunk = $urandom_range(1, (n_payload < 12) ? n_payload : 12);
            pkt = {8'($urandom_range(1, 255))};
            for (int i = 0; i < chunk; i++)
                pkt = {pkt, 8'($urandom)};
            send_packet(pkt, 1'b0);
            n_payload = n_payload - chunk;
        end
    endtask

    task automatic run_directed();
        logic [7:0] pkt[$];
        send_item(8'h55, 1'b0, 1'b0);           // stray byte between packets
        send_item(8'h00, 1'b1, 1'b1);           // one-byte packet
        pkt = {8'h07, 8'hAA};                   // continuation while idle
        send_packet(pkt, 1'b0);
        pkt = {8'h00, 8'h03, 8'h01, 8'h11, 8'h22};
        send_packet(pkt, 1'b0);
        pkt = {8'h05, 8'hFF};                   // completes the message
        send_packet(pkt, 1'b0);
        pkt = {8'h00, 8'h82};                   // abandoned by the next first mark
        send_packet(pkt, 1'b1);
        pkt = {8'h00, 8'h01, 8'h09, 8'h00};
        send_packet(pkt, 1'b0);
        pkt = {8'h00, 8'h81};                   // ends inside the length
        send_packet(pkt, 1'b0);
        pkt = {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h5A, 8'h33};
        send_packet(pkt, 1'b0);                 // length wider than 32 bits
    endtask

    task automatic run_random();
        logic [7:0] pkt[$];
        int         sel;
        int         n;
        int         next_drain;
        next_drain = DRAIN_EVERY;
        while (sb.inputs < ITEM_TARGET) begin
            if (sb.inputs >= ITEM_TARGET - QUIET_TAIL)
                quiet = 1'b1;
            if ($urandom_range(0, 9) == 0)
                tx_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                send_message();
            end else if (sel < 70) begin
                // header, often cut short, sometimes left open
                build_header($urandom_range(1, 400), int'($urandom_range(0, 2)), 2, pkt);
                n = $urandom_range(2, pkt.size());
                while (pkt.size() > n) void'(pkt.pop_back());
                send_packet(pkt, 1'($urandom_range(0, 1)));
            end else if (sel < 80) begin
                pkt = {8'($urandom)};
                n = $urandom_range(1, 7);
                for (int i = 0; i < n; i++)
                    pkt = {pkt, 8'($urandom)};
                send_packet(pkt, 1'b0);
            end else if (sel < 88) begin
                send_item(8'($urandom), 1'b1, 1'b1);
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_item(8'($urandom), 1'($urandom), 1'($urandom));
            end
            if (sb.inputs >= next_drain) begin
                wait_drain();
                next_drain = next_drain + DRAIN_EVERY;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        wait_drain();
        run_random();
        wait_drain();
        repeat (5) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.errors = sb.errors + sb.pending();
            $display("ERROR: %0d results never arrived", sb.pending());
        end
        $display("Run: %0d input bytes (%0d not ignored), %0d results checked",
                 sb.inputs, sb.useful, sb.results);
        $display("     %0d payload bytes, %0d completed messages, %0d mismatches",
                 sb.payloads, sb.messages, sb.errors);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
